// ===== hdl/itoar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoar_pkg
// Types, constants and the digit-to-ASCII mapping shared by the radix
// conversion block, its channels and its checker.
// ----------------------------------------------------------------------------
package itoar_pkg;

   // Field widths
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned RadixWidth = 5;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned StepWidth  = $clog2(WordWidth);

   // Letter case for digits ten and above
   localparam bit UPPER_CASE_DIGITS = 1'b1;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [RadixWidth-1:0] radix_type;
   typedef logic [CharWidth-1:0]  char_type;
   typedef logic [DigitWidth-1:0] digit_type;

   // Radix limits
   localparam radix_type RADIX_MIN = 5'd8;
   localparam radix_type RADIX_MAX = 5'd16;

   // ASCII codes
   localparam char_type CHAR_MINUS   = 8'h2D;
   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_NINE    = 8'h39;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_F = 8'h46;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_F = 8'h66;
   localparam char_type DIGIT_TEN    = 8'd10;

   // Divider status toward the sequencer
   typedef struct packed {
      logic      done;
      digit_type remainder;
   } div_status_type;

   // Digit stack control and status
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

   typedef struct packed {
      logic empty;
   } stack_status_type;

   // Map one digit value to its ASCII character
   function automatic char_type digit_char(input digit_type d);
      char_type d_wide;
      d_wide = {{(CharWidth-DigitWidth){1'b0}}, d};
      if (d_wide < DIGIT_TEN) begin
         return CHAR_ZERO + d_wide;
      end else if (UPPER_CASE_DIGITS) begin
         return CHAR_UPPER_A + (d_wide - DIGIT_TEN);
      end else begin
         return CHAR_LOWER_A + (d_wide - DIGIT_TEN);
      end
   endfunction

endpackage

// ===== hdl/itoar_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoar_if
// Valid/ready channels: the number request and the character response.
// ----------------------------------------------------------------------------
interface itoar_req_if import itoar_pkg::*; ();
   logic      valid;
   logic      ready;
   word_type  value;
   logic      is_signed;
   radix_type radix;

   modport source (output valid, output value, output is_signed, output radix,
                   input ready);
   modport sink   (input valid, input value, input is_signed, input radix,
                   output ready);
endinterface

interface itoar_rsp_if import itoar_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hdl/itoar_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoar_divider
// Restoring divider, 64-bit dividend by a radix of at most sixteen, one
// quotient bit per cycle. Done pulses as the last step is registered.
// ----------------------------------------------------------------------------
module itoar_divider import itoar_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  word_type       dividend,
   input  radix_type      divisor,
   output word_type       quotient,
   output div_status_type status
);

   localparam logic [StepWidth-1:0] StepLast = StepWidth'(WordWidth - 1);

   word_type               quot_ff, quot_in;
   digit_type              rem_ff, rem_in;
   logic [StepWidth-1:0]   step_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [RadixWidth-1:0]  trial;
   logic [RadixWidth-1:0]  diff;
   logic                   fits;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      trial   = {rem_ff, quot_ff[WordWidth-1]};
      fits    = (trial >= divisor);
      diff    = trial - divisor;
      rem_in  = fits ? diff[DigitWidth-1:0] : trial[DigitWidth-1:0];
      quot_in = {quot_ff[WordWidth-2:0], fits};
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == StepLast) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Quotient and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient         = quot_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== hdl/itoar_digit_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoar_digit_stack
// Last-in first-out store of digit characters. Digits come in least
// significant first and leave most significant first; pop data is registered.
// ----------------------------------------------------------------------------
module itoar_digit_stack import itoar_pkg::*; #(
   parameter int unsigned DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  stack_ctrl_type   ctrl,
   input  char_type         push_char,
   output char_type         pop_char,
   output stack_status_type status
);

   localparam int unsigned AddrWidth  = $clog2(DEPTH);
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   char_type               mem [DEPTH];
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  top_idx;
   logic                   full;
   char_type               pop_char_ff;

   assign full    = (count_ff == CountWidth'(DEPTH));
   assign top_idx = count_ff - 1'b1;

   // Track fill level; extra digits past the depth are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.push && !full) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctrl.pop && (count_ff != '0)) begin
         count_ff <= top_idx;
      end
   end

   // Write on push, read the top entry on pop
   always_ff @(posedge clock) begin
      if (ctrl.push && !full) begin
         mem[count_ff[AddrWidth-1:0]] <= push_char;
      end
      if (ctrl.pop && (count_ff != '0)) begin
         pop_char_ff <= mem[top_idx[AddrWidth-1:0]];
      end
   end

   assign pop_char     = pop_char_ff;
   assign status.empty = (count_ff == '0);

endmodule

// ===== hdl/integer_to_ascii_radix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Converts a 64-bit number to ASCII text in radix 8 to 16, most significant
// digit first, with a leading '-' for negative signed values.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                      Word meaning
//  -------  ---  ---------------------------  -----------------------------
//  req      in   value, is_signed, radix      one number to convert
//  rsp      out  character, last              one character, last marks end
//
//  Each digit takes one pass of the shared bit-serial divider: 64 steps plus
//  the start and hand-off states. req ready is high only while no number is
//  in work; the last character may still wait in the output register when
//  the next number is taken. A stalled rsp holds the sequencer before each
//  character; synchronous reset clears the sequencer, the digit stack and
//  the output valid.
//
module integer_to_ascii_radix_top import itoar_pkg::*; #(
   parameter int unsigned DIGIT_STORE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   itoar_req_if.sink   req_port,
   itoar_rsp_if.source rsp_port
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_START,
      ST_DIVIDE,
      ST_POP,
      ST_LOAD
   } state_type;

   state_type        state_ff;
   word_type         work_ff;
   radix_type        radix_ff;
   logic             neg_ff;
   logic             rsp_valid_ff;
   char_type         rsp_char_ff;
   logic             rsp_last_ff;

   word_type         mag_in;
   radix_type        radix_in;
   logic             neg_in;
   logic             slot_free;
   logic             req_take;
   logic             rsp_load;

   logic             div_start;
   word_type         div_quotient;
   div_status_type   div_status;
   stack_ctrl_type   stack_ctrl;
   stack_status_type stack_status;
   char_type         stack_char;

   // Clamp the radix and form the magnitude
   always_comb begin
      priority if (req_port.radix < RADIX_MIN) begin
         radix_in = RADIX_MIN;
      end else if (req_port.radix > RADIX_MAX) begin
         radix_in = RADIX_MAX;
      end else begin
         radix_in = req_port.radix;
      end
      neg_in = req_port.is_signed && req_port.value[WordWidth-1];
      mag_in = neg_in ? (~req_port.value + 1'b1) : req_port.value;
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;

   // A new output word loads this cycle
   assign rsp_load = ((state_ff == ST_SIGN) && neg_ff && slot_free) ||
                     (state_ff == ST_LOAD);

   // Drive the shared divider and the digit stack
   assign div_start       = (state_ff == ST_START);
   assign stack_ctrl.push = (state_ff == ST_DIVIDE) && div_status.done;
   assign stack_ctrl.pop  = (state_ff == ST_POP) && slot_free;

   itoar_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (work_ff),
      .divisor  (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   itoar_digit_stack #(
      .DEPTH (DIGIT_STORE_DEPTH)
   ) u_digit_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stack_ctrl),
      .push_char (digit_char(div_status.remainder)),
      .pop_char  (stack_char),
      .status    (stack_status)
   );

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the output word once taken, unless a new one loads
         if (rsp_valid_ff && rsp_port.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  work_ff  <= mag_in;
                  radix_ff <= radix_in;
                  neg_ff   <= neg_in;
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               if (!neg_ff) begin
                  state_ff <= ST_START;
               end else if (slot_free) begin
                  rsp_char_ff  <= CHAR_MINUS;
                  rsp_last_ff  <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_START;
               end
            end
            ST_START: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_status.done) begin
                  work_ff  <= div_quotient;
                  state_ff <= (div_quotient == '0) ? ST_POP : ST_START;
               end
            end
            ST_POP: begin
               if (slot_free) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               rsp_char_ff  <= stack_char;
               rsp_last_ff  <= stack_status.empty;
               rsp_valid_ff <= 1'b1;
               state_ff     <= stack_status.empty ? ST_IDLE : ST_POP;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.character = rsp_char_ff;
   assign rsp_port.last      = rsp_last_ff;

endmodule

// ===== hdl/itoar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoar_checker
// Port-level checks for the radix conversion block, bound to the top level.
// ----------------------------------------------------------------------------
module itoar_checker import itoar_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input char_type rsp_character,
   input logic     rsp_last
);

   // Hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled response word changed");

   // Drop ready once a number is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a number is in work");

   // The final character is never the minus sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character != CHAR_MINUS)
      else $error("number ended on a minus sign");

   // Every character is a minus sign, a digit or a letter digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS)
         || (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE)
         || (rsp_character >= CHAR_UPPER_A && rsp_character <= CHAR_UPPER_F)
         || (rsp_character >= CHAR_LOWER_A && rsp_character <= CHAR_LOWER_F))
      else $error("response character outside the digit set");

   // Come out of reset with no response pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind integer_to_ascii_radix_top itoar_checker u_itoar_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_character (rsp_port.character),
   .rsp_last      (rsp_port.last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_to_ascii_radix_top. Numbers go in on the
// req channel and ASCII characters come back on rsp. Each accepted number is
// turned into its expected text in radix 8 to 16 by a predictor in the
// scoreboard. Each character that comes back is then checked in order
// against that text. Both sides idle at random, and one long rsp stall
// backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
   import itoar_pkg::*;

   localparam int unsigned RANDOM_NUMBERS = 208;
   localparam int unsigned QUIET_NUMBERS  = 40;
   localparam int unsigned LONG_HOLD      = 4000;
   localparam int unsigned HOLD_AFTER     = 60;
   localparam int unsigned DRAIN_CYCLES   = 200;
   localparam int unsigned CYCLE_LIMIT    = 2000000;

   // One expected character of the text
   typedef struct packed {
      char_type character;
      logic     last;
   } text_char_type;

   // Predict the text of each number, check characters in arrival order
   class radix_text_scoreboard;
      text_char_type expected_text[$];
      int unsigned   error_count;

      function new();
         error_count = 0;
      endfunction

      function char_type ascii_of_digit(input word_type d);
         if (d < 10) begin
            return CHAR_ZERO + char_type'(d);
         end else if (UPPER_CASE_DIGITS) begin
            return CHAR_UPPER_A + char_type'(d - 10);
         end else begin
            return CHAR_LOWER_A + char_type'(d - 10);
         end
      endfunction

      // Build the expected text of one accepted number
      function void note_number(input word_type value, input logic is_signed,
                                input radix_type radix);
         word_type      magnitude;
         word_type      base;
         char_type      digits[$];
         text_char_type entry;
         base = word_type'(radix);
         if (base < word_type'(RADIX_MIN)) begin
            base = word_type'(RADIX_MIN);
         end
         if (base > word_type'(RADIX_MAX)) begin
            base = word_type'(RADIX_MAX);
         end
         magnitude = value;
         // Negative signed: emit the minus sign, then the wrapped magnitude
         if (is_signed && value[WordWidth-1]) begin
            entry.character = CHAR_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
            magnitude = word_type'(0) - value;
         end
         do begin
            digits.push_front(ascii_of_digit(magnitude % base));
            magnitude = magnitude / base;
         end while (magnitude != 0);
         foreach (digits[i]) begin
            entry.character = digits[i];
            entry.last      = (i == digits.size() - 1);
            expected_text.push_back(entry);
         end
      endfunction

      // Compare one returned character with the oldest expectation
      function void check_char(input char_type character, input logic last);
         text_char_type want;
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character %h last %b", $time, character, last);
            error_count++;
            return;
         end
         want = expected_text.pop_front();
         if (want.character !== character) begin
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, want.character, character);
            error_count++;
         end
         if (want.last !== last) begin
            $display("%0t: last mismatch on %h: expected %b, actual %b",
                     $time, want.character, want.last, last);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_text.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned numbers_taken;
   int unsigned cycle_count;
   bit          quiet_tail;

   radix_text_scoreboard text_board = new();

   itoar_req_if req_bus ();
   itoar_rsp_if rsp_bus ();

   integer_to_ascii_radix_top #(
      .DIGIT_STORE_DEPTH(32)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus.sink),
      .rsp_port(rsp_bus.source)
   );

   // Clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         text_board.note_number(req_bus.value, req_bus.is_signed, req_bus.radix);
         numbers_taken <= numbers_taken + 1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         text_board.check_char(rsp_bus.character, rsp_bus.last);
      end
   end

   // Drive rsp ready: short random stalls, one long hold-off mid run
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (!long_hold_done && numbers_taken >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one number and hold it until accepted; return at a falling edge
   task automatic send_number(input word_type value, input logic is_signed,
                              input radix_type radix);
      req_bus.valid     <= 1'b1;
      req_bus.value     <= value;
      req_bus.is_signed <= is_signed;
      req_bus.radix     <= radix;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for a short burst
   task automatic idle_sender();
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // Random number with a spread of digit counts and signs
   function automatic word_type random_number();
      word_type v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: v = v;
         1: v = v >> $urandom_range(0, 63);
         2: v = v >> $urandom_range(40, 63);
         default: v = word_type'(0) - (v >> $urandom_range(0, 63));
      endcase
      return v;
   endfunction

   // Main sequence
   initial begin
      radix_type radix;
      numbers_taken     = 0;
      quiet_tail        = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.value     = '0;
      req_bus.is_signed = 1'b0;
      req_bus.radix     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero, extremes, most negative, every radix, saturation
      send_number(64'd0, 1'b0, 5'd10);
      send_number(64'd0, 1'b1, 5'd16);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd8);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd16);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd10);
      send_number(64'h8000_0000_0000_0000, 1'b1, 5'd8);
      send_number(64'h8000_0000_0000_0000, 1'b1, 5'd10);
      send_number(64'h8000_0000_0000_0000, 1'b0, 5'd16);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd10);
      send_number(64'hFEDC_BA98_7654_3210, 1'b0, 5'd16);
      send_number(64'h0123_4567_89AB_CDEF, 1'b0, 5'd16);
      send_number(64'd9, 1'b0, 5'd9);
      send_number(64'd10, 1'b0, 5'd11);
      send_number(64'd123456789, 1'b0, 5'd12);
      send_number(64'hFFFF_FFFF_FFFF_FF01, 1'b1, 5'd13);
      send_number(64'd987654321, 1'b0, 5'd14);
      send_number(64'd1 << 40, 1'b0, 5'd15);
      send_number(64'd5, 1'b0, 5'd0);
      send_number(64'd100, 1'b0, 5'd7);
      send_number(64'd100, 1'b1, 5'd17);
      send_number(64'hFFFF_FFFF, 1'b0, 5'd31);
      send_number(64'd1, 1'b1, 5'd8);

      // Random numbers; quiet tail without idling
      for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
         if (n >= RANDOM_NUMBERS - QUIET_NUMBERS) begin
            quiet_tail = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            radix = radix_type'($urandom_range(0, 31));
         end else begin
            radix = radix_type'($urandom_range(8, 16));
         end
         send_number(random_number(), 1'($urandom_range(0, 1)), radix);
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            idle_sender();
         end
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding characters, then watch for strays
      while (text_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (text_board.error_count == 0 && text_board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
